FILE: rtl/utf8_stream_decoder_assert.svh
// assertion macros for the utf-8 stream decoder
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// condition holds at every edge outside reset
`define UTF8SD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("utf8sd: invariant violated");

// antecedent at one edge forces the consequent at the next
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8sd: next-cycle check failed");

`endif

FILE: rtl/utf8sd_pkg.sv
`default_nettype none

package utf8sd_pkg;

   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] LEAD_MIN   = 8'hC2;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD_LIMIT = 8'hF5;
   localparam logic [7:0] LEAD_ED    = 8'hED;
   localparam logic [7:0] LEAD_F4    = 8'hF4;
   localparam logic [7:0] CONT_MIN   = 8'h80;
   localparam logic [7:0] CONT_MAX   = 8'hBF;
   localparam logic [7:0] CONT_E0_LO = 8'hA0;
   localparam logic [7:0] CONT_F0_LO = 8'h90;
   localparam logic [7:0] CONT_ED_HI = 8'h9F;
   localparam logic [7:0] CONT_F4_HI = 8'h8F;

   localparam int Q_DEPTH = 4;

   typedef struct packed {
      logic [20:0] code_point;
      logic        valid_res;
      logic [2:0]  seq_bytes;
      logic [31:0] char_index;
      logic        last_char;
   } result_type;

   function automatic logic [2:0] seq_length(input logic [7:0] lead);
      logic [2:0] len;
      if (lead < LEAD3_MIN)      len = 3'd2;
      else if (lead < LEAD4_MIN) len = 3'd3;
      else                       len = 3'd4;
      return len;
   endfunction

   function automatic result_type make_res(input logic [20:0] cp, input logic ok,
                                           input logic [2:0] len);
      result_type r;
      r.code_point = cp;
      r.valid_res  = ok;
      r.seq_bytes  = len;
      r.char_index = '0;
      r.last_char  = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8_stream_decoder.sv
// utf-8 stream decoder with validation
// input channel: one byte a word on req_data_byte, req_end_of_string marks the
//   final byte of a string; a word is taken when req_valid is high and
//   req_stall is low
// result channel: one word per character on the rsp_ ports, taken when rsp_valid
//   is high and rsp_stall is low; a byte breaking a sequence gives the invalid
//   prefix, then its own result unless it is a lead; a lead byte on its own
//   gives none unless it ends the string; an accepted byte is registered and
//   decoded into a four-entry result queue once it has room; rsp_valid is high
//   while the queue holds a word
// throughput: one byte per cycle; the decode register advances only while the
//   result queue holds at most two entries, so a run of double results or a
//   stalled receiver puts three or more words in the queue and then raises req_stall
// reset (synchronous, active high) clears the pending sequence, the character
//   counter, the decode register and the queue; no word is lost while stalled
// char_index counts modulo 2**INDEX_WIDTH and restarts at zero after each string
`default_nettype none

`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder #(
   parameter int INDEX_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_string,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [20:0]      rsp_code_point,
   output logic             rsp_valid_res,
   output logic [2:0]       rsp_seq_bytes,
   output logic [31:0]      rsp_char_index,
   output logic             rsp_last_char
);
   import utf8sd_pkg::*;

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   // decode register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_eos_ff;

   // pending sequence
   logic [7:0]             lead_ff, lead_in;
   logic [1:0]             held_ff, held_in;
   logic [20:0]            part_ff, part_in;
   logic [INDEX_WIDTH-1:0] cnt_ff, cnt_in, cnt_plus1;
   logic [INDEX_WIDTH+31:0] idx0_ext, idx1_ext;

   // result queue
   result_type             q_ff [Q_DEPTH];
   logic [PTR_W-1:0]       head_ff, tail_ff, tail_next;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic        req_take, adv, pop;
   logic        lead_ascii, lead_bad;
   logic [20:0] lead_part;
   logic [7:0]  cont_lo, cont_hi;
   logic        cont_ok, seq_done;
   logic [1:0]  held_c;
   logic [20:0] part_c;
   logic [2:0]  lead_len;
   logic [1:0]  n;
   result_type  res [2];

   assign adv       = s1_valid_ff && (count_ff <= CNT_W'(Q_DEPTH - 2));
   assign req_stall = s1_valid_ff && !adv;
   assign req_take  = req_valid && !req_stall;
   assign pop       = (count_ff != '0) && !rsp_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take)  s1_valid_in = 1'b1;
      else if (adv)  s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
         s1_eos_ff  <= req_end_of_string;
      end
   end

   // classification of the registered byte as a new lead
   assign lead_ascii = s1_byte_ff <= ASCII_MAX;
   assign lead_bad   = !lead_ascii && (s1_byte_ff < LEAD_MIN || s1_byte_ff >= LEAD_LIMIT);
   always_comb begin
      if (s1_byte_ff < LEAD3_MIN)      lead_part = {16'b0, s1_byte_ff[4:0]};
      else if (s1_byte_ff < LEAD4_MIN) lead_part = {17'b0, s1_byte_ff[3:0]};
      else                             lead_part = {18'b0, s1_byte_ff[2:0]};
   end

   // second byte limits tighten after e0, ed, f0 and f4
   always_comb begin
      cont_lo = CONT_MIN;
      cont_hi = CONT_MAX;
      if (held_ff == 2'd1) begin
         if (lead_ff == LEAD3_MIN)      cont_lo = CONT_E0_LO;
         else if (lead_ff == LEAD4_MIN) cont_lo = CONT_F0_LO;
         if (lead_ff == LEAD_ED)        cont_hi = CONT_ED_HI;
         else if (lead_ff == LEAD_F4)   cont_hi = CONT_F4_HI;
      end
   end

   assign cont_ok  = (s1_byte_ff >= cont_lo) && (s1_byte_ff <= cont_hi);
   assign held_c   = held_ff + 2'd1;
   assign part_c   = {part_ff[14:0], s1_byte_ff[5:0]};
   assign lead_len = seq_length(lead_ff);
   assign seq_done = ({1'b0, held_c} >= lead_len) || (held_c == 2'd0);

   assign cnt_plus1 = cnt_ff + INDEX_WIDTH'(1);
   assign idx0_ext  = {32'b0, cnt_ff};
   assign idx1_ext  = {32'b0, cnt_plus1};

   always_comb begin
      res[0]  = '0;
      res[1]  = '0;
      n       = 2'd0;
      held_in = held_ff;
      lead_in = lead_ff;
      part_in = part_ff;
      cnt_in  = cnt_ff;
      if (adv) begin
         if (held_ff == 2'd0) begin
            if (lead_ascii) begin
               res[0] = make_res({13'b0, s1_byte_ff}, 1'b1, 3'd1);
               n      = 2'd1;
            end else if (lead_bad) begin
               res[0] = make_res('0, 1'b0, 3'd1);
               n      = 2'd1;
            end else begin
               held_in = 2'd1;
               lead_in = s1_byte_ff;
               part_in = lead_part;
            end
         end else if (cont_ok) begin
            if (seq_done) begin
               res[0]  = make_res(part_c, 1'b1, lead_len);
               n       = 2'd1;
               held_in = 2'd0;
               lead_in = '0;
               part_in = '0;
            end else begin
               held_in = held_c;
               part_in = part_c;
            end
         end else begin
            // broken sequence: flush the prefix, then decode the byte as a lead
            res[0]  = make_res('0, 1'b0, {1'b0, held_ff});
            n       = 2'd1;
            held_in = 2'd0;
            lead_in = '0;
            part_in = '0;
            if (lead_ascii) begin
               res[1] = make_res({13'b0, s1_byte_ff}, 1'b1, 3'd1);
               n      = 2'd2;
            end else if (lead_bad) begin
               res[1] = make_res('0, 1'b0, 3'd1);
               n      = 2'd2;
            end else begin
               held_in = 2'd1;
               lead_in = s1_byte_ff;
               part_in = lead_part;
            end
         end

         if (s1_eos_ff) begin
            if (held_in != 2'd0) begin
               res[n[0]] = make_res('0, 1'b0, {1'b0, held_in});
               n         = n + 2'd1;
               held_in   = 2'd0;
               lead_in   = '0;
               part_in   = '0;
            end
            if (n == 2'd2) res[1].last_char = 1'b1;
            else           res[0].last_char = 1'b1;
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + INDEX_WIDTH'(n);
         end
      end
      res[0].char_index = idx0_ext[31:0];
      res[1].char_index = idx1_ext[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         lead_ff <= '0;
         part_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         held_ff <= held_in;
         lead_ff <= lead_in;
         part_ff <= part_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign tail_next = tail_ff + PTR_W'(1);
   assign count_in  = count_ff + CNT_W'(n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (n != 2'd0) q_ff[tail_ff]   <= res[0];
      if (n == 2'd2) q_ff[tail_next] <= res[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (pop) head_ff <= head_ff + PTR_W'(1);
         tail_ff  <= tail_ff + PTR_W'(n);
         count_ff <= count_in;
      end
   end

   assign rsp_valid      = count_ff != '0;
   assign rsp_code_point = q_ff[head_ff].code_point;
   assign rsp_valid_res  = q_ff[head_ff].valid_res;
   assign rsp_seq_bytes  = q_ff[head_ff].seq_bytes;
   assign rsp_char_index = q_ff[head_ff].char_index;
   assign rsp_last_char  = q_ff[head_ff].last_char;

   `UTF8SD_ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= CNT_W'(Q_DEPTH))
   `UTF8SD_ASSERT_NEXT(a_eos_clears_count, clock, reset, adv && s1_eos_ff, cnt_ff == '0)
   `UTF8SD_ASSERT_NEXT(a_eos_clears_held, clock, reset, adv && s1_eos_ff, held_ff == 2'd0)

endmodule

`default_nettype wire

FILE: test/utf8_stream_decoder_test.sv
`default_nettype none

module utf8_stream_decoder_test;
   import utf8sd_pkg::*;

   localparam int IDLE_PCT       = 23;
   localparam int RANDOM_BYTES   = 1000;
   localparam int CALM_FROM      = 400;
   localparam int CALM_TO        = 650;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct {
      logic [7:0] data;
      logic       eos;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [20:0] rsp_code_point;
   logic        rsp_valid_res;
   logic [2:0]  rsp_seq_bytes;
   logic [31:0] rsp_char_index;
   logic        rsp_last_char;

   stream_byte_type pending_bytes[$];
   result_type      expected_chars[$];

   // decoder state as predicted
   logic [7:0]  held_lead = '0;
   int          held_count = 0;
   logic [20:0] held_value = '0;
   logic [31:0] next_index = '0;
   int          chars_this_word;

   int  bytes_accepted = 0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  accepted_seen = 0;

   utf8_stream_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_point    (rsp_code_point),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_seq_bytes     (rsp_seq_bytes),
      .rsp_char_index    (rsp_char_index),
      .rsp_last_char     (rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allowed range of the first continuation byte after a lead
   function automatic logic [7:0] second_lo(input logic [7:0] lead);
      if (lead == LEAD3_MIN) return CONT_E0_LO;
      if (lead == LEAD4_MIN) return CONT_F0_LO;
      return CONT_MIN;
   endfunction

   function automatic logic [7:0] second_hi(input logic [7:0] lead);
      if (lead == LEAD_ED) return CONT_ED_HI;
      if (lead == LEAD_F4) return CONT_F4_HI;
      return CONT_MAX;
   endfunction

   function automatic int char_length(input logic [7:0] lead);
      if (lead < LEAD3_MIN) return 2;
      if (lead < LEAD4_MIN) return 3;
      return 4;
   endfunction

   function automatic logic [7:0] pick_edge(input logic [7:0] lo, input logic [7:0] hi);
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return 8'($urandom_range(lo, hi));
   endfunction

   task automatic push_char(input logic [20:0] cp, input logic ok, input int len);
      result_type r;
      r.code_point = cp;
      r.valid_res  = ok;
      r.seq_bytes  = 3'(len);
      r.char_index = next_index;
      r.last_char  = 1'b0;
      expected_chars.push_back(r);
      next_index++;
      chars_this_word++;
   endtask

   task automatic clear_held();
      held_lead  = '0;
      held_count = 0;
      held_value = '0;
   endtask

   task automatic start_char(input logic [7:0] data);
      if (data <= ASCII_MAX) begin
         push_char(21'(data), 1'b1, 1);
      end else if (data < LEAD_MIN || data >= LEAD_LIMIT) begin
         push_char('0, 1'b0, 1);
      end else begin
         held_lead  = data;
         held_count = 1;
         if (data < LEAD3_MIN)      held_value = 21'(data[4:0]);
         else if (data < LEAD4_MIN) held_value = 21'(data[3:0]);
         else                       held_value = 21'(data[2:0]);
      end
   endtask

   task automatic decode_byte(input logic [7:0] data, input logic eos);
      logic [7:0] lo;
      logic [7:0] hi;
      result_type r;
      chars_this_word = 0;
      lo = (held_count == 1) ? second_lo(held_lead) : CONT_MIN;
      hi = (held_count == 1) ? second_hi(held_lead) : CONT_MAX;
      if (held_count == 0) begin
         start_char(data);
      end else if (data >= lo && data <= hi) begin
         held_value = {held_value[14:0], data[5:0]};
         held_count++;
         if (held_count >= char_length(held_lead)) begin
            push_char(held_value, 1'b1, char_length(held_lead));
            clear_held();
         end
      end else begin
         // broken sequence: prefix goes out invalid, the byte starts afresh
         push_char('0, 1'b0, held_count);
         clear_held();
         start_char(data);
      end
      if (eos) begin
         if (held_count != 0) begin
            push_char('0, 1'b0, held_count);
            clear_held();
         end
         if (chars_this_word > 0) begin
            r = expected_chars.pop_back();
            r.last_char = 1'b1;
            expected_chars.push_back(r);
         end
         next_index = '0;
      end
   endtask

   task automatic put_byte(input logic [7:0] data, input logic eos);
      stream_byte_type s;
      s.data = data;
      s.eos  = eos;
      pending_bytes.push_back(s);
   endtask

   // well-formed character of len bytes, of which only the first keep are sent
   task automatic put_seq(input int len, input int keep);
      logic [7:0] seq [4];
      int i;
      if (len == 1) begin
         seq[0] = 8'($urandom_range(0, ASCII_MAX));
      end else begin
         if (len == 2)      seq[0] = 8'($urandom_range(LEAD_MIN, LEAD3_MIN - 1));
         else if (len == 3) seq[0] = 8'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1));
         else               seq[0] = 8'($urandom_range(LEAD4_MIN, LEAD_LIMIT - 1));
         seq[1] = pick_edge(second_lo(seq[0]), second_hi(seq[0]));
         for (i = 2; i < len; i++) seq[i] = pick_edge(CONT_MIN, CONT_MAX);
      end
      for (i = 0; i < keep; i++) put_byte(seq[i], 1'b0);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   function automatic bit calm();
      return bytes_accepted >= CALM_FROM && bytes_accepted < CALM_TO;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         decode_byte(req_data_byte, req_end_of_string);
         void'(pending_bytes.pop_front());
         bytes_accepted++;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || bytes_accepted != accepted_seen) begin
            if (pending_bytes.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid         <= 1'b1;
               req_data_byte     <= pending_bytes[0].data;
               req_end_of_string <= pending_bytes[0].eos;
            end else begin
               req_valid <= 1'b0;
            end
         end
         accepted_seen = bytes_accepted;
         rsp_stall <= !calm() && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: no character expected, got cp %0h valid %0b len %0d index %0d last %0b",
                     $time, rsp_code_point, rsp_valid_res, rsp_seq_bytes, rsp_char_index,
                     rsp_last_char);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            check_field("code_point", 32'(want.code_point), 32'(rsp_code_point));
            check_field("valid_res", 32'(want.valid_res), 32'(rsp_valid_res));
            check_field("seq_bytes", 32'(want.seq_bytes), 32'(rsp_seq_bytes));
            check_field("char_index", want.char_index, rsp_char_index);
            check_field("last_char", 32'(want.last_char), 32'(rsp_last_char));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int target;
      int nchars;
      int c;
      int kind;
      int len;
      int r;
      logic [7:0] lead;
      stream_byte_type s;

      // single bytes: ascii ends, stray cont, overlong, out-of-range lead; edge chars
      put_byte(8'h00, 1'b0); put_byte(ASCII_MAX, 1'b0); put_byte(CONT_MIN, 1'b0);
      put_byte(LEAD_MIN - 8'd1, 1'b0); put_byte(LEAD_LIMIT, 1'b0); put_byte(8'hFF, 1'b1);
      put_byte(LEAD_MIN, 1'b0); put_byte(CONT_MIN, 1'b0);
      put_byte(LEAD3_MIN, 1'b0); put_byte(CONT_E0_LO, 1'b0); put_byte(CONT_MIN, 1'b0);
      put_byte(LEAD_F4, 1'b0); put_byte(CONT_F4_HI, 1'b0); put_byte(CONT_MAX, 1'b0);
      put_byte(CONT_MAX, 1'b1);
      // second byte just outside its window breaks the sequence
      put_byte(LEAD3_MIN, 1'b0); put_byte(CONT_E0_LO - 8'd1, 1'b0);
      put_byte(LEAD_ED, 1'b0); put_byte(CONT_ED_HI + 8'd1, 1'b0);
      put_byte(LEAD4_MIN, 1'b0); put_byte(CONT_F0_LO - 8'd1, 1'b0);
      put_byte(LEAD_F4, 1'b0); put_byte(CONT_F4_HI + 8'd1, 1'b1);
      // string ends on a three-byte prefix
      put_byte(LEAD4_MIN, 1'b0); put_byte(CONT_F0_LO, 1'b0); put_byte(CONT_MIN, 1'b1);

      target = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < target) begin
         nchars = $urandom_range(1, 12);
         for (c = 0; c < nchars; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               len = $urandom_range(1, 4);
               put_seq(len, len);
            end else if (kind < 84) begin
               len = $urandom_range(2, 4);
               put_seq(len, $urandom_range(1, len - 1));
            end else if (kind < 93) begin
               lead = 8'($urandom_range(LEAD_MIN, LEAD_LIMIT - 1));
               put_byte(lead, 1'b0);
               r = $urandom_range(0, 2);
               if (r == 0)      put_byte(second_lo(lead) - 8'd1, 1'b0);
               else if (r == 1) put_byte(second_hi(lead) + 8'd1, 1'b0);
               else             put_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
               put_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         end
         s = pending_bytes.pop_back();
         s.eos = 1'b1;
         pending_bytes.push_back(s);
      end

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
